@@ sv/spi_slave_line_command_port_assert.svh @@
// assertion macros of the spi line command port rtl, used by sslcp_ctrl
// expects clk and rst_n in the scope of each use
`ifndef SPI_SLAVE_LINE_COMMAND_PORT_ASSERT_SVH
`define SPI_SLAVE_LINE_COMMAND_PORT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define SSLCP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SSLCP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/sslcp_pkg.sv @@
// shared constants and types of the spi line command port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sslcp_pkg;

  localparam int MSG_BYTES = 128;
  localparam int MSG_AW    = $clog2(MSG_BYTES);
  localparam int CNT_W     = $clog2(MSG_BYTES + 1);
  localparam int LINE_DEPTH = 2 * MSG_BYTES;
  localparam int LINE_AW   = $clog2(LINE_DEPTH);

  localparam logic [2:0] ACT_SPI     = 3'd0;
  localparam logic [2:0] ACT_NSS     = 3'd1;
  localparam logic [2:0] ACT_RESP    = 3'd2;
  localparam logic [2:0] ACT_READ    = 3'd3;
  localparam logic [2:0] ACT_RELEASE = 3'd4;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CAP_RESET = 8'd128;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data_byte;
    logic       data_last;
    logic       rx_valid;
    logic       tx_empty;
    logic       overrun;
    logic       mode_fault;
    logic       nss_level;
    logic [6:0] cmd_index;
  } in_item_t;

  typedef struct packed {
    logic               line_we;
    logic [LINE_AW-1:0] line_waddr;
    logic [7:0]         line_wdata;
    logic [LINE_AW-1:0] line_raddr;
    logic               reply_we;
    logic [MSG_AW-1:0]  reply_waddr;
    logic [7:0]         reply_wdata;
    logic [MSG_AW-1:0]  reply_raddr;
  } mem_req_t;

  typedef struct packed {
    logic       tx_valid;
    logic       tx_from_mem;
    logic       cmd_from_mem;
    logic [7:0] cmd_length;
    logic       cmd_pending;
    logic       response_ready;
  } res_meta_t;

endpackage

`default_nettype wire

@@ sv/sslcp_ram.sv @@
// generic single write port ram with one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module sslcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ sv/sslcp_ctrl.sv @@
// controller of the spi line command port: phase, counters, bank select,
// capacity register and the memory requests; uses sslcp_pkg and the assertion header
`timescale 1ns / 1ps
`default_nettype none
`include "spi_slave_line_command_port_assert.svh"

module sslcp_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire sslcp_pkg::in_item_t item,
  input  wire logic                cfg_we,
  input  wire logic [7:0]          cfg_wdata,
  output sslcp_pkg::mem_req_t      mem_req,
  output sslcp_pkg::res_meta_t     meta
);

  import sslcp_pkg::*;

  localparam logic [2:0] PH_IDLE         = 3'd0;
  localparam logic [2:0] PH_CMD_RX       = 3'd1;
  localparam logic [2:0] PH_CMD_READY    = 3'd2;
  localparam logic [2:0] PH_RESP_READY   = 3'd4;
  localparam logic [2:0] PH_RESP_SENDING = 3'd5;
  localparam logic [2:0] PH_RESP_SENT    = 3'd6;

  localparam logic [CNT_W-1:0]   CNT_MAX    = CNT_W'(MSG_BYTES);
  localparam logic [CNT_W-1:0]   CNT_ONE    = CNT_W'(1);
  localparam logic [LINE_AW-1:0] BANK1_BASE = LINE_AW'(MSG_BYTES);
  localparam logic [7:0]         IDX_MAX    = 8'(MSG_BYTES);

  logic [7:0]       cap_r;
  logic [2:0]       phase_r, phase_nxt;
  logic [CNT_W-1:0] line_count_r, line_count_nxt;
  logic             bank_r, bank_nxt;
  logic [CNT_W-1:0] cmd_len_r, cmd_len_nxt;
  logic             waiting_r, waiting_nxt;
  logic [CNT_W-1:0] reply_len_r, reply_len_nxt;
  logic [CNT_W-1:0] reply_pos_r, reply_pos_nxt;
  logic [CNT_W-1:0] reply_fill_r, reply_fill_nxt;
  logic             prev_nss_r, prev_nss_nxt;

  logic [7:0] cap_m1;
  logic [7:0] len8;
  logic [7:0] vis_len;

  always_comb begin
    phase_nxt      = phase_r;
    line_count_nxt = line_count_r;
    bank_nxt       = bank_r;
    cmd_len_nxt    = cmd_len_r;
    waiting_nxt    = waiting_r;
    reply_len_nxt  = reply_len_r;
    reply_pos_nxt  = reply_pos_r;
    reply_fill_nxt = reply_fill_r;
    prev_nss_nxt   = prev_nss_r;

    mem_req.line_we     = 1'b0;
    mem_req.line_waddr  = bank_r ? (BANK1_BASE + LINE_AW'(line_count_r))
                                 : LINE_AW'(line_count_r);
    mem_req.line_wdata  = item.data_byte;
    mem_req.reply_we    = 1'b0;
    mem_req.reply_waddr = reply_fill_r[MSG_AW-1:0];
    mem_req.reply_wdata = item.data_byte;
    mem_req.reply_raddr = reply_pos_r[MSG_AW-1:0];

    meta.tx_valid    = 1'b0;
    meta.tx_from_mem = 1'b0;

    if (accept) begin
      case (item.action)
        ACT_SPI: begin
          if (item.rx_valid && (phase_r == PH_IDLE || phase_r == PH_CMD_RX)
              && item.data_byte != CHAR_CR) begin
            if (item.data_byte == CHAR_LF) begin
              if (line_count_r != '0) begin
                cmd_len_nxt = line_count_r;
                waiting_nxt = 1'b1;
                bank_nxt    = ~bank_r;
                phase_nxt   = PH_CMD_READY;
              end
              line_count_nxt = '0;
            end else if (line_count_r < CNT_MAX) begin
              mem_req.line_we = 1'b1;
              line_count_nxt  = line_count_r + CNT_ONE;
              phase_nxt       = PH_CMD_RX;
            end
          end
          if (item.tx_empty) begin
            meta.tx_valid = 1'b1;
            if (phase_nxt == PH_RESP_READY || phase_nxt == PH_RESP_SENDING) begin
              if (reply_pos_r < reply_len_r && reply_pos_r < CNT_MAX) begin
                meta.tx_from_mem = 1'b1;
                reply_pos_nxt    = reply_pos_r + CNT_ONE;
                phase_nxt        = PH_RESP_SENDING;
              end else begin
                phase_nxt = PH_RESP_SENT;
              end
            end
          end
          // overrun and mode fault do the same thing, applying once suffices
          if ((item.overrun || item.mode_fault) && phase_nxt != PH_RESP_READY
              && phase_nxt != PH_RESP_SENDING) begin
            phase_nxt      = PH_IDLE;
            line_count_nxt = '0;
          end
        end
        ACT_NSS: begin
          if (!prev_nss_r && item.nss_level) begin
            if (phase_r == PH_RESP_SENDING || phase_r == PH_RESP_SENT) begin
              phase_nxt     = PH_IDLE;
              reply_pos_nxt = '0;
            end
            if (phase_r == PH_CMD_RX) begin
              phase_nxt      = PH_IDLE;
              line_count_nxt = '0;
            end
          end
          prev_nss_nxt = item.nss_level;
        end
        ACT_RESP: begin
          if (reply_fill_r < CNT_MAX) begin
            mem_req.reply_we = 1'b1;
            reply_fill_nxt   = reply_fill_r + CNT_ONE;
          end
          if (item.data_last) begin
            reply_len_nxt  = reply_fill_nxt;
            reply_pos_nxt  = '0;
            reply_fill_nxt = '0;
            phase_nxt      = PH_RESP_READY;
          end
        end
        ACT_RELEASE: begin
          if (cap_r != 8'd0) begin
            waiting_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end

    // visible length after the step, clipped to capacity minus one; zero when no command waits or capacity is zero
    cap_m1 = cap_r - 8'd1;
    len8   = 8'(cmd_len_nxt);
    if (!waiting_nxt || cap_r == 8'd0) begin
      vis_len = 8'd0;
    end else if (len8 > cap_m1) begin
      vis_len = cap_m1;
    end else begin
      vis_len = len8;
    end

    mem_req.line_raddr = bank_nxt ? LINE_AW'(item.cmd_index)
                                  : (BANK1_BASE + LINE_AW'(item.cmd_index));

    meta.cmd_from_mem   = (8'(item.cmd_index) < vis_len) && (8'(item.cmd_index) < IDX_MAX);
    meta.cmd_length     = vis_len;
    meta.cmd_pending    = waiting_nxt;
    meta.response_ready = (phase_nxt == PH_RESP_READY);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r        <= CAP_RESET;
      phase_r      <= PH_IDLE;
      line_count_r <= '0;
      bank_r       <= 1'b0;
      cmd_len_r    <= '0;
      waiting_r    <= 1'b0;
      reply_len_r  <= '0;
      reply_pos_r  <= '0;
      reply_fill_r <= '0;
      prev_nss_r   <= 1'b1;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      phase_r      <= phase_nxt;
      line_count_r <= line_count_nxt;
      bank_r       <= bank_nxt;
      cmd_len_r    <= cmd_len_nxt;
      waiting_r    <= waiting_nxt;
      reply_len_r  <= reply_len_nxt;
      reply_pos_r  <= reply_pos_nxt;
      reply_fill_r <= reply_fill_nxt;
      prev_nss_r   <= prev_nss_nxt;
    end
  end

  `SSLCP_ASSERT_IMP(a_line_we_rx, mem_req.line_we, accept && item.action == ACT_SPI && item.rx_valid, "line store written outside a receive item")
  `SSLCP_ASSERT_IMP(a_count_bound, 1'b1, line_count_r <= CNT_MAX && reply_fill_r <= CNT_MAX, "line or reply count beyond buffer size")
  `SSLCP_ASSERT_NXT(a_resp_load, accept && item.action == ACT_RESP && item.data_last, phase_r == PH_RESP_READY && reply_fill_r == '0 && reply_pos_r == '0, "response load did not arm the response")
  `SSLCP_ASSERT_IMP(a_tx_mem_phase, meta.tx_from_mem, phase_nxt == PH_RESP_SENDING && reply_pos_r < reply_len_r, "response byte sent outside a send")

endmodule

`default_nettype wire

@@ sv/spi_slave_line_command_port.sv @@
// spi line command port: one result item per input item; a result passes the
// memory read register (stage one) and then the output register, after which
// out_tvalid rises and the result can be taken
// sustained rate one item per clock; the only stall is a full output stage
// with out_tready low
// rst_n is synchronous: it clears phase, counters, bank and capacity (128);
// the line and reply memories are not cleared and hold garbage until written
`timescale 1ns / 1ps
`default_nettype none

module spi_slave_line_command_port (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // data_byte[7:0], rx_valid[8], tx_empty[9], overrun[10], mode_fault[11],
  // nss_level[12], cmd_index[19:13], zero fill [23:20]
  input  wire logic [23:0] in_tdata,
  // action[2:0]
  input  wire logic [2:0]  in_tuser,
  // data_last
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tx_valid[0], tx_byte[8:1], cmd_byte[16:9], cmd_length[24:17],
  // cmd_pending[25], response_ready[26], zero fill [31:27]
  output logic      [31:0] out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);

  import sslcp_pkg::*;

  in_item_t  item;
  mem_req_t  mem_req;
  res_meta_t meta;
  res_meta_t s1_meta_r;
  logic      s1_valid_r;
  logic      s1_move;
  logic      accept;
  logic [7:0] line_rdata;
  logic [7:0] reply_rdata;
  logic [7:0] tx_byte;
  logic [7:0] cmd_byte;
  logic [31:0] out_data_r;
  logic        out_valid_r;

  assign item.action     = in_tuser;
  assign item.data_byte  = in_tdata[7:0];
  assign item.data_last  = in_tlast;
  assign item.rx_valid   = in_tdata[8];
  assign item.tx_empty   = in_tdata[9];
  assign item.overrun    = in_tdata[10];
  assign item.mode_fault = in_tdata[11];
  assign item.nss_level  = in_tdata[12];
  assign item.cmd_index  = in_tdata[19:13];

  assign cfg_ready = 1'b1;
  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_move;
  assign accept    = in_tvalid && in_tready;

  sslcp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (item),
    .cfg_we    (cfg_valid),
    .cfg_wdata (cfg_data),
    .mem_req   (mem_req),
    .meta      (meta)
  );

  // read data holds while stage one is stalled since reads fire on accept only
  sslcp_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_line_ram (
    .clk   (clk),
    .we    (mem_req.line_we),
    .waddr (mem_req.line_waddr),
    .wdata (mem_req.line_wdata),
    .re    (accept),
    .raddr (mem_req.line_raddr),
    .rdata (line_rdata)
  );

  sslcp_ram #(.WIDTH(8), .DEPTH(MSG_BYTES)) u_reply_ram (
    .clk   (clk),
    .we    (mem_req.reply_we),
    .waddr (mem_req.reply_waddr),
    .wdata (mem_req.reply_wdata),
    .re    (accept),
    .raddr (mem_req.reply_raddr),
    .rdata (reply_rdata)
  );

  assign tx_byte  = s1_meta_r.tx_from_mem ? reply_rdata : 8'd0;
  assign cmd_byte = s1_meta_r.cmd_from_mem ? line_rdata : 8'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta_r <= meta;
    end
    if (s1_move) begin
      out_data_r <= {5'd0, s1_meta_r.response_ready, s1_meta_r.cmd_pending,
                     s1_meta_r.cmd_length, cmd_byte, tx_byte, s1_meta_r.tx_valid};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
